// ----- hw/rtl/psba_pkg.sv -----
// Shared types and constants of the paged store block allocator.
`timescale 1ns / 1ps
`default_nettype none
package psba_pkg;

   // Default store geometry
   localparam int PAGES_DEF      = 64;
   localparam int PAGE_BYTES_DEF = 64;

   // Field widths
   localparam int CFG_W   = 7;
   localparam int PAGE_W  = 6;
   localparam int OFF_W   = 6;
   localparam int BYTE_W  = 8;
   localparam int CMD_W   = 2;
   // Page cursor: holds start + block_pages for any 7-bit settings
   localparam int CNT_W   = 8;

   // Port widths
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_TUSER_W = 1;
   localparam int CSR_INDEX_W = 1;

   // Register indexes and reset values
   localparam logic [CSR_INDEX_W-1:0] REG_PAGES_IN_USE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_PAGES  = 1'd1;
   localparam logic [CFG_W-1:0]       PAGES_IN_USE_RST = 7'd64;
   localparam logic [CFG_W-1:0]       BLOCK_PAGES_RST  = 7'd4;

   // Status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_WRITE = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [CFG_W-1:0] pages_in_use;
      logic [CFG_W-1:0] block_pages;
   } cfg_type;

   typedef struct packed {
      cmd_type           command;
      logic [PAGE_W-1:0] page_index;
      logic [OFF_W-1:0]  byte_offset;
      logic [BYTE_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [PAGE_W-1:0] first_page;
      logic [BYTE_W-1:0] read_data;
   } rsp_type;

endpackage
`default_nettype wire

// ----- hw/rtl/psba_ram.sv -----
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module psba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/psba_ctrl.sv -----
// Command sequencer: bitmap scan, block mark and clear, byte access, clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module psba_ctrl #(
   parameter int PAGES      = psba_pkg::PAGES_DEF,
   parameter int PAGE_BYTES = psba_pkg::PAGE_BYTES_DEF,
   localparam int PG_W   = $clog2(PAGES),
   localparam int DEPTH  = PAGES * PAGE_BYTES,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire psba_pkg::cfg_type cfg,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire psba_pkg::req_type req_item,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output psba_pkg::rsp_type      rsp_item,
   // allocation bitmap
   output logic                   bm_we,
   output logic [PG_W-1:0]        bm_waddr,
   output logic                   bm_wdata,
   output logic [PG_W-1:0]        bm_raddr,
   input  wire logic              bm_rdata,
   // page bytes
   output logic                   byte_we,
   output logic [ADDR_W-1:0]      byte_waddr,
   output logic [psba_pkg::BYTE_W-1:0] byte_wdata,
   output logic [ADDR_W-1:0]      byte_raddr,
   input  wire logic [psba_pkg::BYTE_W-1:0] byte_rdata
);
   import psba_pkg::*;

   localparam logic [CFG_W-1:0] NCAP = CFG_W'((PAGES > 127) ? 127 : PAGES);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_SCAN,
      ST_CHECK,
      ST_WRITE,
      ST_RESP
   } state_type;

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   cmd_type              cmd_ff, cmd_in;
   logic [CNT_W-1:0]     q_ff, q_in;
   logic [CNT_W-1:0]     start_ff, start_in;
   logic [PAGE_W-1:0]    page_ff, page_in;
   logic [OFF_W-1:0]     off_ff, off_in;
   logic [BYTE_W-1:0]    wd_ff, wd_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   rsp_type              pend_ff, pend_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [CFG_W-1:0]     n_w;
   logic [CNT_W-1:0]     n_c;
   logic [CNT_W-1:0]     end_c;
   logic [CNT_W-1:0]     q_inc;
   logic                 bad_rng;
   logic                 out_free;
   logic                 fin;
   rsp_type              fin_res;
   logic                 acc_ok;
   logic                 expect_bit;
   logic [ADDR_W-1:0]    req_addr;

   assign n_w      = (cfg.pages_in_use > NCAP) ? NCAP : cfg.pages_in_use;
   assign n_c      = CNT_W'(n_w);
   assign end_c    = start_ff + CNT_W'(cfg.block_pages);
   assign q_inc    = q_ff + CNT_W'(1);
   assign bad_rng  = (cfg.block_pages == '0) || (start_ff >= n_c) || (end_c > n_c);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_addr = ADDR_W'(32'(req_item.page_index) * PAGE_BYTES
                             + 32'(req_item.byte_offset));

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      q_in         = q_ff;
      start_in     = start_ff;
      page_in      = page_ff;
      off_in       = off_ff;
      wd_in        = wd_ff;
      addr_in      = addr_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      fin          = 1'b0;
      fin_res      = '{status: STATUS_FAIL, first_page: '0, read_data: '0};
      acc_ok       = 1'b0;
      expect_bit   = (cmd_ff == CMD_FREE);
      bm_we        = 1'b0;
      byte_we      = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            byte_we = 1'b1;
            bm_we   = (32'(clr_ff) < PAGES);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_item.command;
               page_in  = req_item.page_index;
               off_in   = req_item.byte_offset;
               wd_in    = req_item.write_data;
               addr_in  = req_addr;
               start_in = CNT_W'(req_item.page_index);
               if (req_item.command == CMD_ALLOC) begin
                  q_in     = '0;
                  state_in = ST_SCAN;
               end else if (req_item.command == CMD_FREE) begin
                  q_in     = CNT_W'(req_item.page_index);
                  state_in = ST_CHECK;
               end else begin
                  q_in     = CNT_W'(req_item.page_index);
                  state_in = ST_ACCESS;
               end
            end
         end
         ST_ACCESS: begin
            acc_ok  = ({1'b0, page_ff} < n_w) && bm_rdata && (32'(off_ff) < PAGE_BYTES);
            byte_we = acc_ok && (cmd_ff == CMD_WRITE);
            fin     = 1'b1;
            fin_res.status = acc_ok ? STATUS_OK : STATUS_FAIL;
            if (acc_ok && (cmd_ff == CMD_READ)) begin
               fin_res.read_data = byte_rdata;
            end
         end
         ST_SCAN: begin
            // first free page among the managed ones
            if (q_ff >= n_c) begin
               fin = 1'b1;
            end else if (bm_rdata) begin
               q_in = q_inc;
            end else begin
               start_in = q_ff;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // alloc wants every page free, free wants every page allocated
            if (bad_rng || (bm_rdata != expect_bit)) begin
               fin = 1'b1;
            end else if (q_inc == end_c) begin
               q_in     = start_ff;
               state_in = ST_WRITE;
            end else begin
               q_in = q_inc;
            end
         end
         ST_WRITE: begin
            bm_we = 1'b1;
            if (q_inc == end_c) begin
               fin            = 1'b1;
               fin_res.status = STATUS_OK;
               if (cmd_ff == CMD_ALLOC) begin
                  fin_res.first_page = start_ff[PAGE_W-1:0];
               end
            end else begin
               q_in = q_inc;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hand the result to the output register, or hold it while that is full
      if (fin) begin
         if (out_free) begin
            rsp_in       = fin_res;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            pend_in  = fin_res;
            state_in = ST_RESP;
         end
      end
   end

   // Each command's writes land no later than the edge that ends it; the next command's
   // reads are issued from ST_IDLE after that edge, so no forwarding is needed.
   assign bm_raddr   = PG_W'(q_in);
   assign bm_waddr   = (state_ff == ST_CLEAR) ? PG_W'(clr_ff) : PG_W'(q_ff);
   assign bm_wdata   = (state_ff != ST_CLEAR) && (cmd_ff == CMD_ALLOC);
   assign byte_raddr = req_addr;
   assign byte_waddr = (state_ff == ST_CLEAR) ? clr_ff : addr_ff;
   assign byte_wdata = (state_ff == ST_CLEAR) ? '0 : wd_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff   <= cmd_in;
      q_ff     <= q_in;
      start_ff <= start_in;
      page_ff  <= page_in;
      off_ff   <= off_in;
      wd_ff    <= wd_in;
      addr_ff  <= addr_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != ST_IDLE)
      else $error("accepted transaction did not start a command");

   a_no_result_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid_ff)
      else $error("result during clearing pass");

   a_write_inside_block: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> (q_ff >= start_ff) && (q_ff < end_c))
      else $error("bitmap update outside the block");

   a_resp_holds_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESP |-> rsp_valid_ff)
      else $error("pending result while output register empty");

endmodule
`default_nettype wire

// ----- hw/rtl/paged_store_block_allocator_top.sv -----
// Top level of the paged store block allocator: ports, settings registers, memories.
// read_byte/write_byte access one byte. alloc_block finds the first free page, then
// checks that every page of the block is free and marks it; free_block checks that
// every page is allocated and clears it; early failures end sooner. The single read
// port of the bitmap gives one page per cycle; a new transaction is taken only once
// the last has ended. After reset a clearing pass over PAGES * PAGE_BYTES addresses
// zeroes both memories, takes no transaction and takes settings writes as ever.
`timescale 1ns / 1ps
`default_nettype none
module paged_store_block_allocator_top #(
   parameter int PAGES      = psba_pkg::PAGES_DEF,
   parameter int PAGE_BYTES = psba_pkg::PAGE_BYTES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // page_index[5:0], byte_offset[11:6], write_data[19:12], zero pad
   input  wire logic [psba_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // command[1:0]
   input  wire logic [psba_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // first_page[5:0], read_data[13:6], zero pad
   output logic      [psba_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // status[0]
   output logic      [psba_pkg::RSP_TUSER_W-1:0]    rsp_tuser,
   input  wire logic                                csr_we,
   input  wire logic [psba_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [psba_pkg::CFG_W-1:0]          csr_wdata
);
   import psba_pkg::*;

   localparam int PG_W   = $clog2(PAGES);
   localparam int DEPTH  = PAGES * PAGE_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [CFG_W-1:0] pages_in_use_ff;
   logic [CFG_W-1:0] block_pages_ff;
   cfg_type          cfg;
   req_type          req_item;
   rsp_type          rsp_item;

   logic              bm_we;
   logic [PG_W-1:0]   bm_waddr;
   logic              bm_wdata;
   logic [PG_W-1:0]   bm_raddr;
   logic              bm_rdata;
   logic              byte_we;
   logic [ADDR_W-1:0] byte_waddr;
   logic [BYTE_W-1:0] byte_wdata;
   logic [ADDR_W-1:0] byte_raddr;
   logic [BYTE_W-1:0] byte_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         pages_in_use_ff <= PAGES_IN_USE_RST;
         block_pages_ff  <= BLOCK_PAGES_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PAGES_IN_USE: pages_in_use_ff <= csr_wdata;
            REG_BLOCK_PAGES:  block_pages_ff  <= csr_wdata;
            default: begin
               pages_in_use_ff <= pages_in_use_ff;
            end
         endcase
      end
   end

   assign cfg.pages_in_use = pages_in_use_ff;
   assign cfg.block_pages  = block_pages_ff;

   assign req_item.command     = cmd_type'(req_tuser[CMD_W-1:0]);
   assign req_item.page_index  = req_tdata[PAGE_W-1:0];
   assign req_item.byte_offset = req_tdata[PAGE_W+OFF_W-1:PAGE_W];
   assign req_item.write_data  = req_tdata[PAGE_W+OFF_W+BYTE_W-1:PAGE_W+OFF_W];

   assign rsp_tdata = {(RSP_TDATA_W - PAGE_W - BYTE_W)'(0), rsp_item.read_data,
                       rsp_item.first_page};
   assign rsp_tuser = rsp_item.status;

   psba_ctrl #(
      .PAGES      (PAGES),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item),
      .bm_we      (bm_we),
      .bm_waddr   (bm_waddr),
      .bm_wdata   (bm_wdata),
      .bm_raddr   (bm_raddr),
      .bm_rdata   (bm_rdata),
      .byte_we    (byte_we),
      .byte_waddr (byte_waddr),
      .byte_wdata (byte_wdata),
      .byte_raddr (byte_raddr),
      .byte_rdata (byte_rdata)
   );

   psba_ram #(
      .WIDTH (1),
      .DEPTH (PAGES)
   ) u_bitmap (
      .clock (clock),
      .we    (bm_we),
      .waddr (bm_waddr),
      .wdata (bm_wdata),
      .raddr (bm_raddr),
      .rdata (bm_rdata)
   );

   psba_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_bytes (
      .clock (clock),
      .we    (byte_we),
      .waddr (byte_waddr),
      .wdata (byte_wdata),
      .raddr (byte_raddr),
      .rdata (byte_rdata)
   );

endmodule
`default_nettype wire
